>>> rtl/scbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_pkg
// Types, constants and helpers shared by the size-class buffer pool.
// ----------------------------------------------------------------------------
package scbp_pkg;

    localparam int CLASS_COUNT = 6;
    localparam int STACK_DEPTH = 64;
    localparam int HANDLE_BITS = 16;
    localparam int REG_COUNT   = 6;

    localparam int SIZE_W   = 16;
    localparam int HANDLE_W = 16;
    localparam int CLSIDX_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CLS_W    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W   = $clog2(CLASS_COUNT * STACK_DEPTH);
    localparam int MEM_DEPTH = CLASS_COUNT * STACK_DEPTH;

    typedef enum logic [1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_RETURN = 2'd1,
        KIND_FLUSH  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_POOLED    = 3'd2,
        ST_OVERSIZE  = 3'd3,
        ST_FULL      = 3'd4,
        ST_UNDERSIZE = 3'd5,
        ST_FLUSHED   = 3'd6
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic [SIZE_W-1:0]   byte_size;
        logic [HANDLE_W-1:0] buffer_handle;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] out_handle;
        logic [CLSIDX_W-1:0] class_index;
        logic [SIZE_W-1:0]   fresh_size;
    } result_t;

    typedef struct packed {
        logic              alloc_found;
        logic [CLS_W-1:0]  alloc_cls;
        logic [SIZE_W-1:0] alloc_limit;
        logic              ret_found;
        logic [CLS_W-1:0]  ret_cls;
        logic              ret_exact;
    } sel_t;

    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic                   flush;
        logic [CLS_W-1:0]       cls;
        logic [HANDLE_BITS-1:0] wdata;
    } stack_op_t;

    typedef logic [CLASS_COUNT-1:0][CNT_W-1:0] count_arr_t;

    function automatic logic [SIZE_W-1:0] limit_reset(input int idx);
        logic [SIZE_W-1:0] val;
        unique case (idx)
            0: val = 16'd60;
            1: val = 16'd124;
            2: val = 16'd400;
            3: val = 16'd650;
            4: val = 16'd900;
            5: val = 16'd1524;
            default: val = 16'd65535;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

>>> rtl/scbp_class_sel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_class_sel
// Class limit registers and the parallel compares that pick the alloc class
// (first limit at or above the size) and the return class (last limit at or
// below the size).
// ----------------------------------------------------------------------------
module scbp_class_sel (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [scbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scbp_pkg::SIZE_W-1:0]   cfg_data,
    input  wire logic [scbp_pkg::SIZE_W-1:0]   byte_size,
    output scbp_pkg::sel_t                     sel
);
    import scbp_pkg::*;

    logic [CLASS_COUNT-1:0][SIZE_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                limit_reg[i] <= limit_reset(i);
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                if (i < REG_COUNT && int'(cfg_index) == i)
                begin
                    limit_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        sel = '0;
        // descending scan: lowest matching class wins
        for (int i = CLASS_COUNT - 1; i >= 0; i--)
        begin
            if (byte_size <= limit_reg[i])
            begin
                sel.alloc_found = 1'b1;
                sel.alloc_cls   = CLS_W'(i);
                sel.alloc_limit = limit_reg[i];
            end
        end
        // ascending scan: highest matching class wins
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            if (byte_size >= limit_reg[i])
            begin
                sel.ret_found = 1'b1;
                sel.ret_cls   = CLS_W'(i);
                sel.ret_exact = (byte_size == limit_reg[i]);
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/scbp_stacks.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbp_stacks
// Per-class fill counts and the shared handle memory holding every class's
// LIFO stack; one push or pop per beat, read data registered.
// ----------------------------------------------------------------------------
module scbp_stacks (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire scbp_pkg::stack_op_t              op,
    output scbp_pkg::count_arr_t                  counts,
    output logic [scbp_pkg::HANDLE_BITS-1:0]      rd_data
);
    import scbp_pkg::*;

    count_arr_t             count_reg;
    count_arr_t             count_next;
    logic [HANDLE_BITS-1:0] mem [MEM_DEPTH];
    logic [HANDLE_BITS-1:0] rd_data_reg;
    logic [CNT_W-1:0]       cur_cnt;
    logic [ADDR_W-1:0]      base;
    logic [ADDR_W-1:0]      addr;

    assign cur_cnt = count_reg[op.cls];
    assign base    = ADDR_W'(op.cls) * ADDR_W'(STACK_DEPTH);

    always_comb
    begin
        if (op.pop)
        begin
            addr = base + ADDR_W'(cur_cnt - CNT_W'(1));
        end
        else
        begin
            addr = base + ADDR_W'(cur_cnt);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (op.flush)
        begin
            count_next = '0;
        end
        else if (op.push)
        begin
            count_next[op.cls] = cur_cnt + CNT_W'(1);
        end
        else if (op.pop)
        begin
            count_next[op.cls] = cur_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[addr] <= op.wdata;
        end
        if (op.pop)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign counts  = count_reg;
    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> rtl/size_class_buffer_pool_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_buffer_pool_top
// Buffer handle recycler with six size classes, each a LIFO of free handles.
// ----------------------------------------------------------------------------
// One request is taken every clock (busy never rises); each alloc, return or
// flush gives exactly one result, in request order, shown for one cycle with
// done high and not held. The request register is followed by the result
// register, loaded alongside the stack memory's registered read port.
// A no-op kind gives no result.
// Limit writes on the cfg channel are always ready and belong between
// requests. Stack contents need no clearing after reset.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire scbp_pkg::item_t                item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [scbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scbp_pkg::SIZE_W-1:0]    cfg_data,
    output logic                                done,
    output scbp_pkg::result_t                   result
);
    import scbp_pkg::*;

    item_t                  item_reg;
    logic                   item_valid_reg;
    sel_t                   sel;
    stack_op_t              op;
    count_arr_t             counts;
    logic [HANDLE_BITS-1:0] rd_data;
    result_t                res_next;
    result_t                res_reg;
    logic                   res_valid_next;
    logic                   res_valid_reg;
    logic [CNT_W-1:0]       alloc_cnt;
    logic [CNT_W-1:0]       ret_cnt;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
    end

    scbp_class_sel u_class_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_size (item_reg.byte_size),
        .sel       (sel)
    );

    assign alloc_cnt = counts[sel.alloc_cls];
    assign ret_cnt   = counts[sel.ret_cls];

    always_comb
    begin
        op             = '0;
        op.wdata       = HANDLE_BITS'(item_reg.buffer_handle);
        res_next       = '0;
        res_next.class_index = CLSIDX_W'(CLASS_COUNT);
        res_valid_next = 1'b0;
        if (item_valid_reg)
        begin
            unique case (item_reg.kind)
                KIND_ALLOC:
                begin
                    res_valid_next  = 1'b1;
                    res_next.status = ST_MISS;
                    res_next.fresh_size = item_reg.byte_size;
                    if (sel.alloc_found)
                    begin
                        res_next.class_index = CLSIDX_W'(sel.alloc_cls);
                        op.cls = sel.alloc_cls;
                        if (alloc_cnt != '0)
                        begin
                            op.pop              = 1'b1;
                            res_next.status     = ST_HIT;
                            res_next.fresh_size = '0;
                        end
                        else
                        begin
                            res_next.fresh_size = sel.alloc_limit;
                        end
                    end
                end
                KIND_RETURN:
                begin
                    res_valid_next  = 1'b1;
                    res_next.status = ST_UNDERSIZE;
                    if (sel.ret_found)
                    begin
                        res_next.class_index = CLSIDX_W'(sel.ret_cls);
                        op.cls = sel.ret_cls;
                        priority if (!sel.ret_exact)
                        begin
                            res_next.status = ST_OVERSIZE;
                        end
                        else if (ret_cnt >= CNT_W'(STACK_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            op.push         = 1'b1;
                            res_next.status = ST_POOLED;
                        end
                    end
                end
                KIND_FLUSH:
                begin
                    res_valid_next  = 1'b1;
                    op.flush        = 1'b1;
                    res_next.status = ST_FLUSHED;
                end
                KIND_NOP:
                begin
                    res_valid_next = 1'b0;
                end
            endcase
        end
    end

    scbp_stacks u_stacks (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .counts  (counts),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        result = res_reg;
        if (res_reg.status == ST_HIT)
        begin
            result.out_handle = HANDLE_W'(rd_data);
        end
    end

    assign done = res_valid_reg;

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        op.push |-> (counts[op.cls] < CNT_W'(STACK_DEPTH)))
        else $error("push into a full stack");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op.pop |-> (counts[op.cls] != '0))
        else $error("pop from an empty stack");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        op.flush |=> (counts == '0))
        else $error("stack counts not cleared by flush");

    a_done_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(item_valid_reg))
        else $error("result without a request");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for size_class_buffer_pool_top. A scoreboard mirrors the
// class limits and the per-class free-handle stacks, predicts the result of
// every accepted request and matches it against the done beats in order.
// Runs a short directed sweep, then bursty random traffic under several limit
// settings: reset values, random ascending, all zero, all maximum, unordered,
// duplicated extremes, and back to the reset values.
// ----------------------------------------------------------------------------
module tb;
    import scbp_pkg::*;

    localparam logic [SIZE_W-1:0] DEFAULT_LIMIT [REG_COUNT] =
        '{16'd60, 16'd124, 16'd400, 16'd650, 16'd900, 16'd1524};
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int SETTLE_CYCLES   = 4;

    class pool_scoreboard;
        logic [SIZE_W-1:0]      limit [CLASS_COUNT];
        logic [HANDLE_BITS-1:0] lifo [CLASS_COUNT][STACK_DEPTH];
        int unsigned            lifo_fill [CLASS_COUNT];
        result_t                due_results [$];
        int                     errors;

        function new();
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                limit[c]     = (c < REG_COUNT) ? DEFAULT_LIMIT[c] : '1;
                lifo_fill[c] = 0;
            end
            errors = 0;
        endfunction

        function void set_limit(int idx, logic [SIZE_W-1:0] val);
            if (idx < REG_COUNT && idx < CLASS_COUNT)
                limit[idx] = val;
        endfunction

        function void note_request(item_t req);
            result_t want;
            bit      found;
            int      c;
            want  = '0;
            found = 1'b0;
            want.class_index = CLSIDX_W'(CLASS_COUNT);
            case (req.kind)
                KIND_ALLOC:
                begin
                    want.status     = ST_MISS;
                    want.fresh_size = req.byte_size;
                    for (c = 0; c < CLASS_COUNT; c++)
                    begin
                        if (!found && req.byte_size <= limit[c])
                        begin
                            found            = 1'b1;
                            want.class_index = CLSIDX_W'(c);
                            if (lifo_fill[c] > 0)
                            begin
                                lifo_fill[c]--;
                                want.out_handle = HANDLE_W'(lifo[c][lifo_fill[c]]);
                                want.status     = ST_HIT;
                                want.fresh_size = '0;
                            end
                            else
                                want.fresh_size = limit[c];
                        end
                    end
                end
                KIND_RETURN:
                begin
                    want.status = ST_UNDERSIZE;
                    for (c = CLASS_COUNT - 1; c >= 0; c--)
                    begin
                        if (!found && req.byte_size >= limit[c])
                        begin
                            found            = 1'b1;
                            want.class_index = CLSIDX_W'(c);
                            if (req.byte_size > limit[c])
                                want.status = ST_OVERSIZE;
                            else if (lifo_fill[c] >= STACK_DEPTH)
                                want.status = ST_FULL;
                            else
                            begin
                                lifo[c][lifo_fill[c]] = req.buffer_handle[HANDLE_BITS-1:0];
                                lifo_fill[c]++;
                                want.status = ST_POOLED;
                            end
                        end
                    end
                end
                KIND_FLUSH:
                begin
                    for (c = 0; c < CLASS_COUNT; c++)
                        lifo_fill[c] = 0;
                    want.status = ST_FLUSHED;
                end
                default:
                    return;
            endcase
            due_results.push_back(want);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: status %0d handle %0h class %0d fresh %0d",
                       got.status, got.out_handle, got.class_index, got.fresh_size);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.out_handle !== want.out_handle)
            begin
                $error("out_handle: expected %0h, got %0h", want.out_handle, got.out_handle);
                errors++;
            end
            if (got.class_index !== want.class_index)
            begin
                $error("class_index: expected %0d, got %0d", want.class_index,
                       got.class_index);
                errors++;
            end
            if (got.fresh_size !== want.fresh_size)
            begin
                $error("fresh_size: expected %0d, got %0d", want.fresh_size, got.fresh_size);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 done;
    result_t              result;

    pool_scoreboard sb;

    size_class_buffer_pool_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("size_class_buffer_pool_top test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    function automatic item_t make_request(kind_t k, logic [SIZE_W-1:0] size,
                                           logic [HANDLE_W-1:0] handle);
        item_t req;
        req.kind          = k;
        req.byte_size     = size;
        req.buffer_handle = handle;
        return req;
    endfunction

    function automatic item_t random_request();
        item_t             req;
        int                pick;
        int                c;
        logic [SIZE_W-1:0] lim;
        pick = $urandom_range(0, 99);
        c    = $urandom_range(0, CLASS_COUNT - 1);
        lim  = sb.limit[c];
        req.buffer_handle = HANDLE_W'($urandom);
        req.byte_size     = SIZE_W'($urandom);
        if (pick < 5)
            req.kind = kind_t'($urandom_range(0, 3));
        else if (pick < 7)
            req.kind = KIND_FLUSH;
        else if (pick < 10)
            req.kind = KIND_NOP;
        else if (pick < 52)
        begin
            req.kind = KIND_ALLOC;
            case ($urandom_range(0, 3))
                0: req.byte_size = lim;
                1: req.byte_size = SIZE_W'($urandom_range(0, lim));
                2: req.byte_size = (lim == '1) ? lim : lim + 1'b1;
                default: ;
            endcase
        end
        else
        begin
            req.kind = KIND_RETURN;
            case ($urandom_range(0, 5))
                0, 1, 2: req.byte_size = lim;
                3: req.byte_size = lim + SIZE_W'($urandom_range(1, 50));
                4: req.byte_size = lim - 1'b1;
                default: ;
            endcase
        end
        return req;
    endfunction

    task automatic send_request(input item_t req);
        start <= 1'b1;
        item  <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(req);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_limits(input logic [SIZE_W-1:0] vals [REG_COUNT],
                                  input bit hit_unused);
        int                last;
        logic [SIZE_W-1:0] val;
        last = hit_unused ? (1 << CFG_IDX_W) - 1 : REG_COUNT - 1;
        for (int idx = 0; idx <= last; idx++)
        begin
            val = (idx < REG_COUNT) ? vals[idx] : SIZE_W'($urandom);
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(idx);
            cfg_data  <= val;
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            sb.set_limit(idx, val);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int    sent;
        int    burst;
        int    c;
        item_t req;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // push one class to near or past full, then pop part of it back
                c     = $urandom_range(0, CLASS_COUNT - 1);
                burst = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 6);
                for (int i = 0; i < burst; i++)
                    send_request(make_request(KIND_RETURN, sb.limit[c], HANDLE_W'($urandom)));
                for (int i = 0; i < burst / 2; i++)
                    send_request(make_request(KIND_ALLOC, sb.limit[c], HANDLE_W'($urandom)));
                sent += burst + burst / 2;
            end
            else
            begin
                burst = $urandom_range(1, 40);
                for (int i = 0; i < burst; i++)
                begin
                    req = random_request();
                    send_request(req);
                    if (req.kind != KIND_NOP)
                        sent++;
                end
            end
            if ($urandom_range(0, 19) == 0)
                drain();
            else if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        logic [SIZE_W-1:0] vals [REG_COUNT];
        logic [SIZE_W-1:0] acc;
        int                waited;

        sb = new();
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    acc = '0;
                    for (int i = 0; i < REG_COUNT; i++)
                    begin
                        acc     = acc + SIZE_W'($urandom_range(0, 400));
                        vals[i] = acc;
                    end
                end
                2: vals = '{default: '0};
                3: vals = '{default: '1};
                4:
                    for (int i = 0; i < REG_COUNT; i++)
                        vals[i] = SIZE_W'($urandom_range(0, 3000));
                5: vals = '{16'd0, 16'd1, 16'd100, 16'd100, 16'd65535, 16'd65535};
                default: vals = DEFAULT_LIMIT;
            endcase
            if (phase > 0)
            begin
                drain();
                program_limits(vals, phase == 4);
            end
            else
            begin
                send_request(make_request(KIND_ALLOC, 16'd0, 16'h1234));
                send_request(make_request(KIND_ALLOC, 16'hFFFF, 16'hFFFF));
                send_request(make_request(KIND_ALLOC, 16'd1525, 16'h0000));
                send_request(make_request(KIND_RETURN, 16'd60, 16'hFFFF));
                send_request(make_request(KIND_RETURN, 16'd60, 16'h0000));
                send_request(make_request(KIND_ALLOC, 16'd60, 16'h5555));
                send_request(make_request(KIND_ALLOC, 16'd1, 16'hAAAA));
                send_request(make_request(KIND_RETURN, 16'd61, 16'h0001));
                send_request(make_request(KIND_RETURN, 16'd59, 16'h0002));
                send_request(make_request(KIND_RETURN, 16'd0, 16'h0003));
                send_request(make_request(KIND_RETURN, 16'hFFFF, 16'h0004));
                send_request(make_request(KIND_RETURN, 16'd1524, 16'hA5A5));
                send_request(make_request(KIND_RETURN, 16'd124, 16'h5A5A));
                send_request(make_request(KIND_RETURN, 16'd400, 16'h8001));
                send_request(make_request(KIND_RETURN, 16'd650, 16'h7FFE));
                send_request(make_request(KIND_RETURN, 16'd900, 16'hC3C3));
                send_request(make_request(KIND_NOP, 16'hFFFF, 16'hFFFF));
                send_request(make_request(KIND_ALLOC, 16'd1524, 16'h0000));
                send_request(make_request(KIND_ALLOC, 16'd650, 16'h0000));
                send_request(make_request(KIND_FLUSH, 16'hFFFF, 16'hFFFF));
                send_request(make_request(KIND_ALLOC, 16'd124, 16'h0000));
                send_request(make_request(KIND_ALLOC, 16'd61, 16'h0000));
                send_request(make_request(KIND_ALLOC, 16'd901, 16'h0000));
                idle_for(3);
            end
            run_random(ITEMS_PER_PHASE);
        end

        start <= 1'b0;
        waited = 0;
        while (sb.due_results.size() != 0 && waited < 500)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.due_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("size_class_buffer_pool_top test passed");
        else
            $display("size_class_buffer_pool_top test failed");
        $finish;
    end

endmodule
